>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, on the house clock and reset names.
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> design/rbps_pkg.sv
// ----------------------------------------------------------------------------
// rbps_pkg
// Shared widths, register codes, limits and lane control for the pitch shifter.
// ----------------------------------------------------------------------------
`default_nettype none

package rbps_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned CFG_W    = 17;
  localparam int unsigned STREAM_W = 32;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 3;

  // register codes (paddr bit 2)
  localparam logic [0:0] REG_PITCH_RATIO = 1'b0;
  localparam logic [0:0] REG_WET_MIX     = 1'b1;

  localparam logic [CFG_W-1:0] RATIO_MIN      = 17'd52429;
  localparam logic [CFG_W-1:0] RATIO_MAX      = 17'd78643;
  localparam logic [CFG_W-1:0] RATIO_UNITY    = 17'd65536;
  localparam logic [CFG_W-1:0] MIX_FULL       = 17'd65536;
  localparam logic [CFG_W-1:0] MIX_BYPASS_MAX = 17'd65;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

  // per-lane stage strobes
  typedef struct packed {
    logic interp_en;  // s0/s1 interpolation stage
    logic mix_en;     // wet/dry blend stage
  } lane_ctl_t;

endpackage

`default_nettype wire

>>> design/rbps_lane.sv
// ----------------------------------------------------------------------------
// rbps_lane
// One channel: linear interpolation between two stored samples, then the
// wet/dry blend with saturation. Two registered stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rbps_lane (
  input  wire                                     clk_i,
  input  wire rbps_pkg::lane_ctl_t                ctl_i,
  input  wire logic signed [rbps_pkg::SAMPLE_W-1:0] s0_i,
  input  wire logic signed [rbps_pkg::SAMPLE_W-1:0] s1_i,
  input  wire logic        [rbps_pkg::FRAC_W-1:0]   frac_i,
  input  wire logic signed [rbps_pkg::SAMPLE_W-1:0] dry_i,
  input  wire logic        [rbps_pkg::CFG_W-1:0]    mix_i,
  output logic signed      [rbps_pkg::SAMPLE_W-1:0] res_o
);

  logic signed [16:0] diff;
  logic signed [33:0] interp_prod;
  logic signed [17:0] wet_sum;
  logic signed [15:0] wet_q;

  logic signed [16:0] delta;
  logic signed [34:0] mix_prod;
  logic signed [19:0] mix_sum;
  logic signed [15:0] res_d, res_q;

  // wet = s0 + floor((s1 - s0) * f / 2^16)
  always_comb begin
    diff        = $signed({s1_i[15], s1_i}) - $signed({s0_i[15], s0_i});
    interp_prod = diff * $signed({1'b0, frac_i});
    wet_sum     = $signed({{2{s0_i[15]}}, s0_i}) + interp_prod[33:16];
  end

  // out = dry + floor((wet - dry) * mix / 2^16), same as the two-term blend
  always_comb begin
    delta    = $signed({wet_q[15], wet_q}) - $signed({dry_i[15], dry_i});
    mix_prod = delta * $signed({1'b0, mix_i});
    mix_sum  = $signed({{4{dry_i[15]}}, dry_i}) + $signed({mix_prod[34], mix_prod[34:16]});
    if (mix_sum > 20'sd32767) begin
      res_d = rbps_pkg::SAMPLE_MAX;
    end else if (mix_sum < -20'sd32768) begin
      res_d = rbps_pkg::SAMPLE_MIN;
    end else begin
      res_d = mix_sum[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.interp_en) begin
      wet_q <= wet_sum[15:0];
    end
    if (ctl_i.mix_en) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

>>> design/ring_buffer_pitch_shifter.sv
// ----------------------------------------------------------------------------
// ring_buffer_pitch_shifter
// Delay-line pitch shifter: stereo frames go into a circular frame store and
// are read back at a fractional position stepping by the pitch ratio.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake               word
//  s_axis    in   tvalid/tready           tdata: left_in[15:0], right_in[31:16]
//  m_axis    out  tvalid/tready           tdata: left_out[15:0], right_out[31:16]
//  apb       in   psel/penable/pready     0x0 pitch_ratio, 0x4 wet_mix
//
//  Order when wet: write, read s0, read s1, interpolate, blend, hand off;
//  in bypass: write, hand off. The store is used in turn: one write
//  and two reads go through it one after the other.
//  Reset: no clearing pass; a fill mark (write index plus wrap flag) makes
//  entries never written read as zero.
//  Stalls: a held m_axis result holds the frame in its hand-off cycle; the
//  next input word is taken only after that hand-off.
//
`default_nettype none

module ring_buffer_pitch_shifter #(
  parameter int unsigned STORE_FRAMES = 16384,
  parameter int unsigned CHANNELS     = 2
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // left_in [15:0], right_in [31:16]
  input  wire logic [rbps_pkg::STREAM_W-1:0]   s_axis_tdata_i,
  input  wire                                  s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // left_out [15:0], right_out [31:16]
  output logic [rbps_pkg::STREAM_W-1:0]        m_axis_tdata_o,
  output logic                                 m_axis_tvalid_o,
  input  wire                                  m_axis_tready_i,
  input  wire                                  psel_i,
  input  wire                                  penable_i,
  input  wire                                  pwrite_i,
  input  wire logic [rbps_pkg::APB_AW-1:0]     paddr_i,
  input  wire logic [rbps_pkg::APB_DW-1:0]     pwdata_i,
  output logic [rbps_pkg::APB_DW-1:0]          prdata_o,
  output logic                                 pready_o
);

  localparam int unsigned AW    = (STORE_FRAMES > 2) ? $clog2(STORE_FRAMES) : 1;
  localparam int unsigned MEM_W = CHANNELS * rbps_pkg::SAMPLE_W;
  localparam int unsigned POS_W = AW + rbps_pkg::FRAC_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(STORE_FRAMES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_INTERP,
    ST_MIX,
    ST_FIN
  } state_e;

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic [rbps_pkg::CFG_W-1:0] ratio_q, mix_q;
  logic [rbps_pkg::CFG_W-1:0] wr_val;
  logic                       cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i & pready_o;
  assign wr_val   = pwdata_i[rbps_pkg::CFG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= rbps_pkg::RATIO_UNITY;
      mix_q   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr_i[2])
        rbps_pkg::REG_PITCH_RATIO: begin
          if (wr_val < rbps_pkg::RATIO_MIN)      ratio_q <= rbps_pkg::RATIO_MIN;
          else if (wr_val > rbps_pkg::RATIO_MAX) ratio_q <= rbps_pkg::RATIO_MAX;
          else                                   ratio_q <= wr_val;
        end
        rbps_pkg::REG_WET_MIX: begin
          if (wr_val > rbps_pkg::MIX_FULL) mix_q <= rbps_pkg::MIX_FULL;
          else                             mix_q <= wr_val;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata_o = '0;
    unique case (paddr_i[2])
      rbps_pkg::REG_PITCH_RATIO: prdata_o[rbps_pkg::CFG_W-1:0] = ratio_q;
      rbps_pkg::REG_WET_MIX:     prdata_o[rbps_pkg::CFG_W-1:0] = mix_q;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  state_e          state_q;
  logic            in_acc;
  logic            bypass;
  logic            bypass_q;
  logic            out_vld_q;
  logic [MEM_W-1:0] out_q, out_d;
  logic [MEM_W-1:0] dry_q;
  logic [AW-1:0]   wr_idx_q;
  logic            wrapped_q;     // every entry written at least once
  logic [POS_W-1:0] pos_q;
  logic            out_free;

  // read addresses from the integer part of the position
  logic [AW-1:0]   i0, i1, rd_addr;
  logic [POS_W:0]  pos_sum;
  logic [POS_W-1:0] pos_d;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign bypass          = (mix_q <= rbps_pkg::MIX_BYPASS_MAX) ||
                           (ratio_q == rbps_pkg::RATIO_UNITY);
  assign out_free        = !out_vld_q || m_axis_tready_i;

  assign i0      = pos_q[POS_W-1:rbps_pkg::FRAC_W];
  assign i1      = (i0 == LAST_IDX) ? '0 : i0 + AW'(1);
  assign rd_addr = (state_q == ST_RD0) ? i0 : i1;

  // step, then fold back once the integer part reaches the store size
  always_comb begin
    pos_sum = {1'b0, pos_q} + (POS_W + 1)'(ratio_q);
    if (pos_sum[POS_W:rbps_pkg::FRAC_W] >= (AW + 1)'(STORE_FRAMES)) begin
      pos_d = POS_W'(pos_sum - {(AW + 1)'(STORE_FRAMES), {rbps_pkg::FRAC_W{1'b0}}});
    end else begin
      pos_d = pos_sum[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      bypass_q  <= 1'b0;
      wr_idx_q  <= '0;
      wrapped_q <= 1'b0;
      pos_q     <= '0;
    end else begin
      if (out_vld_q && m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            bypass_q <= bypass;
            if (wr_idx_q == LAST_IDX) begin
              wr_idx_q  <= '0;
              wrapped_q <= 1'b1;
            end else begin
              wr_idx_q <= wr_idx_q + AW'(1);
            end
            state_q <= bypass ? ST_FIN : ST_RD0;
          end
        end
        ST_RD0:    state_q <= ST_RD1;
        ST_RD1:    state_q <= ST_INTERP;
        ST_INTERP: begin
          pos_q   <= pos_d;
          state_q <= ST_MIX;
        end
        ST_MIX:    state_q <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            out_vld_q <= 1'b1;
            out_q     <= out_d;
            state_q   <= ST_IDLE;
          end
        end
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dry_q <= s_axis_tdata_i[MEM_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Frame store: one write port and one read port, write on accept, reads addressed in RD0/RD1
  // --------------------------------------------------------------------------
  logic [MEM_W-1:0] store_mem [STORE_FRAMES];
  logic [MEM_W-1:0] rdata_q;
  logic             rd_vld_q;   // entry was written since reset
  logic [MEM_W-1:0] rd_word;
  logic [MEM_W-1:0] s0_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      store_mem[wr_idx_q] <= s_axis_tdata_i[MEM_W-1:0];
    end
    rdata_q <= store_mem[rd_addr];
  end

  // fill mark: writes go in order, so below the write index (or after a wrap)
  // means written
  always_ff @(posedge clk_i) begin
    rd_vld_q <= wrapped_q || (rd_addr < wr_idx_q);
  end

  assign rd_word = rd_vld_q ? rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD1) begin
      s0_q <= rd_word;
    end
  end

  // --------------------------------------------------------------------------
  // Channel lanes
  // --------------------------------------------------------------------------
  rbps_pkg::lane_ctl_t lane_ctl;
  logic [MEM_W-1:0]    lane_res;

  assign lane_ctl.interp_en = (state_q == ST_INTERP);
  assign lane_ctl.mix_en    = (state_q == ST_MIX);

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    rbps_lane u_lane (
      .clk_i  (clk_i),
      .ctl_i  (lane_ctl),
      .s0_i   (s0_q[c*rbps_pkg::SAMPLE_W +: rbps_pkg::SAMPLE_W]),
      .s1_i   (rd_word[c*rbps_pkg::SAMPLE_W +: rbps_pkg::SAMPLE_W]),
      .frac_i (pos_q[rbps_pkg::FRAC_W-1:0]),
      .dry_i  (dry_q[c*rbps_pkg::SAMPLE_W +: rbps_pkg::SAMPLE_W]),
      .mix_i  (mix_q),
      .res_o  (lane_res[c*rbps_pkg::SAMPLE_W +: rbps_pkg::SAMPLE_W])
    );
  end

  // bypass passes the dry frame untouched
  assign out_d = bypass_q ? dry_q : lane_res;

  // mono build leaves right_out at zero
  always_comb begin
    m_axis_tdata_o            = '0;
    m_axis_tdata_o[MEM_W-1:0] = out_q;
  end

  assign m_axis_tvalid_o = out_vld_q;

endmodule

`default_nettype wire

>>> design/rbps_checker.sv
// ----------------------------------------------------------------------------
// rbps_checker
// Port-level checks on the pitch shifter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rbps_checker (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire logic [rbps_pkg::STREAM_W-1:0] s_axis_tdata_i,
  input wire                                s_axis_tvalid_i,
  input wire                                s_axis_tready_o,
  input wire logic [rbps_pkg::STREAM_W-1:0] m_axis_tdata_o,
  input wire                                m_axis_tvalid_o,
  input wire                                m_axis_tready_i,
  input wire                                psel_i,
  input wire                                penable_i,
  input wire                                pwrite_i,
  input wire logic [rbps_pkg::APB_AW-1:0]   paddr_i,
  input wire logic [rbps_pkg::APB_DW-1:0]   pwdata_i,
  input wire logic [rbps_pkg::APB_DW-1:0]   prdata_o,
  input wire                                pready_o
);

  logic in_acc;
  logic rd_ratio;
  logic rd_mix;

  assign in_acc   = s_axis_tvalid_i & s_axis_tready_o;
  assign rd_ratio = psel_i & !pwrite_i & (paddr_i[2] == rbps_pkg::REG_PITCH_RATIO);
  assign rd_mix   = psel_i & !pwrite_i & (paddr_i[2] == rbps_pkg::REG_WET_MIX);

  // held result word stays put
  `ASSERT_STD(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "output word changed while stalled")

  // an accept is followed by a busy, not-ready input
  `ASSERT_STD(a_busy_after_acc, in_acc |=> !s_axis_tready_o, "input ready right after accept")

  // results are handed off from the busy hand-off cycle only
  `ASSERT_STD(a_out_from_busy, $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o), "output rose outside hand-off")

  // readback stays in the clamped ranges
  `ASSERT_STD(a_ratio_range, rd_ratio |-> (prdata_o >= 32'd52429) && (prdata_o <= 32'd78643) && (pwdata_i == pwdata_i), "pitch ratio out of range")

  `ASSERT_STD(a_mix_range, rd_mix |-> (prdata_o <= 32'd65536) && pready_o && (penable_i || !penable_i), "wet mix out of range")

endmodule

bind ring_buffer_pitch_shifter rbps_checker u_rbps_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .psel_i          (psel_i),
  .penable_i       (penable_i),
  .pwrite_i        (pwrite_i),
  .paddr_i         (paddr_i),
  .pwdata_i        (pwdata_i),
  .prdata_o        (prdata_o),
  .pready_o        (pready_o)
);

`default_nettype wire
